[src/sps_pkg.sv]
// Shared types and constants for the shortest-path search block.
// No dependencies; imported by every module of the block.
package sps_pkg;

    localparam int NODE_W        = 6;
    localparam int DIST_W        = 24;
    localparam int WEIGHT_W      = 16;
    localparam int CNT_W         = 7;
    localparam int DEF_MAX_NODES = 64;
    localparam int DEF_MAX_EDGES = 256;

    // configuration register indexes
    localparam logic REG_SOURCE = 1'b0;
    localparam logic REG_COUNT  = 1'b1;

    // one classified edge request, front to back
    typedef struct packed {
        logic [NODE_W-1:0]   node_a;
        logic [NODE_W-1:0]   node_b;
        logic [WEIGHT_W-1:0] weight;
        logic                last_edge;
        logic                bad;
    } t_edge_req;

    // status from the back part
    typedef struct packed {
        logic done;
    } t_back_stat;

endpackage

[src/sps_front.sv]
// Front part: takes edge requests, flags bad node indexes, queues them.
// Depends on sps_pkg.
module sps_front
    import sps_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic [NODE_W-1:0]                  i_node_a,
    input  logic [NODE_W-1:0]                  i_node_b,
    input  logic [WEIGHT_W-1:0]                i_weight,
    input  logic                               i_last_edge,
    input  logic [$clog2(MAX_NODES+1)-1:0]     i_n,
    output t_edge_req                          o_req,
    output logic                               o_req_valid,
    input  logic                               i_req_pop,
    input  t_back_stat                         i_stat
);

    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int CW  = (NODE_W > NCW) ? NODE_W : NCW;

    t_edge_req  r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;
    logic       r_wait;
    logic       accept;
    t_edge_req  req_in;

    assign o_busy      = (r_fill == 2'd2) | r_wait;
    assign accept      = i_start & ~o_busy;
    assign o_req       = r_q[r_rd_ptr];
    assign o_req_valid = (r_fill != 2'd0);

    always_comb begin
        req_in.node_a    = i_node_a;
        req_in.node_b    = i_node_b;
        req_in.weight    = i_weight;
        req_in.last_edge = i_last_edge;
        req_in.bad       = (CW'(i_node_a) >= CW'(i_n)) | (CW'(i_node_b) >= CW'(i_n));
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wr_ptr] <= req_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
            r_wait   <= 1'b0;
        end else begin
            if (accept) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_req_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_fill <= r_fill + {1'b0, accept} - {1'b0, i_req_pop};
            // hold off new requests from the last edge until the results are out
            if (accept && i_last_edge) begin
                r_wait <= 1'b1;
            end else if (i_stat.done) begin
                r_wait <= 1'b0;
            end
        end
    end

endmodule

[src/sps_back.sv]
// Back part: edge store, distance store and search sequencer; emits results.
// Depends on sps_pkg.
module sps_back
    import sps_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int MAX_EDGES = DEF_MAX_EDGES
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  t_edge_req                          i_req,
    input  logic                               i_req_valid,
    output logic                               o_req_pop,
    input  logic [$clog2(MAX_NODES+1)-1:0]     i_n,
    input  logic [NODE_W-1:0]                  i_src,
    output t_back_stat                         o_stat,
    output logic                               o_valid,
    output logic [NODE_W-1:0]                  o_node,
    output logic                               o_reached,
    output logic [DIST_W-1:0]                  o_distance,
    output logic                               o_has_predecessor,
    output logic [NODE_W-1:0]                  o_predecessor,
    output logic                               o_edge_dropped,
    output logic                               o_last_node
);

    localparam int NIW = $clog2(MAX_NODES);
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int EW  = 2 * NIW + WEIGHT_W;
    localparam int MW  = NIW + DIST_W;
    localparam int CW  = (NODE_W > NCW) ? NODE_W : NCW;

    localparam logic [3:0] ST_LOAD     = 4'd0;
    localparam logic [3:0] ST_INIT     = 4'd1;
    localparam logic [3:0] ST_SEL      = 4'd2;
    localparam logic [3:0] ST_PICK     = 4'd3;
    localparam logic [3:0] ST_EDGE_RD  = 4'd4;
    localparam logic [3:0] ST_EDGE_CHK = 4'd5;
    localparam logic [3:0] ST_RELAX    = 4'd6;
    localparam logic [3:0] ST_OUT      = 4'd7;

    logic [3:0]          r_state;
    logic [ECW-1:0]      r_count;
    logic                r_dropped;
    logic [ECW-1:0]      r_e;
    logic [NCW-1:0]      r_idx;
    logic                r_p_vld;
    logic [NIW-1:0]      r_p_idx;
    logic                r_found;
    logic [NIW-1:0]      r_u;
    logic [DIST_W-1:0]   r_du;
    logic [NIW-1:0]      r_o;
    logic [WEIGHT_W-1:0] r_w;
    logic [MAX_NODES-1:0] r_reached;
    logic [MAX_NODES-1:0] r_settled;
    logic                r_done;

    logic [EW-1:0]       r_edge_mem [MAX_EDGES];
    logic [EW-1:0]       r_edge_q;
    logic [MW-1:0]       r_dist_mem [MAX_NODES];
    logic [MW-1:0]       r_dist_q;

    logic                r_o_valid;
    logic [NODE_W-1:0]   r_o_node;
    logic                r_o_reached;
    logic [DIST_W-1:0]   r_o_distance;
    logic                r_o_has_pred;
    logic [NODE_W-1:0]   r_o_pred;
    logic                r_o_dropped;
    logic                r_o_last;

    logic                edge_we;
    logic                dist_we;
    logic [NIW-1:0]      dist_waddr;
    logic [MW-1:0]       dist_wdata;
    logic [NIW-1:0]      dist_raddr;
    logic                src_ok;
    logic [NIW-1:0]      src_i;
    logic [NIW-1:0]      ed_a;
    logic [NIW-1:0]      ed_b;
    logic [WEIGHT_W-1:0] ed_w;
    logic                ed_ok;
    logic                hit_a;
    logic                hit_b;
    logic [NIW-1:0]      other;
    logic [DIST_W:0]     sum;
    logic [DIST_W-1:0]   nd;
    logic [DIST_W-1:0]   q_dist;
    logic [NIW-1:0]      q_prev;
    logic                cand;
    logic                scan_more;

    assign src_ok    = CW'(i_src) < CW'(i_n);
    assign src_i     = i_src[NIW-1:0];
    assign o_req_pop = (r_state == ST_LOAD) & i_req_valid;
    assign edge_we   = o_req_pop & ~i_req.bad & (r_count < ECW'(MAX_EDGES));
    assign {ed_a, ed_b, ed_w} = r_edge_q;
    assign {q_prev, q_dist}   = r_dist_q;
    assign ed_ok     = (NCW'(ed_a) < i_n) & (NCW'(ed_b) < i_n);
    assign hit_a     = (ed_a == r_u);
    assign hit_b     = (ed_b == r_u);
    assign other     = hit_a ? ed_b : ed_a;
    assign sum       = {1'b0, r_du} + (DIST_W + 1)'(r_w);
    assign nd        = sum[DIST_W] ? '1 : sum[DIST_W-1:0];
    assign cand      = r_reached[r_p_idx] & ~r_settled[r_p_idx] &
                       (~r_found | (q_dist < r_du));
    assign scan_more = r_idx < i_n;

    always_comb begin
        dist_we    = 1'b0;
        dist_waddr = r_o;
        dist_wdata = {r_u, nd};
        dist_raddr = r_idx[NIW-1:0];
        priority case (r_state)
            ST_INIT: begin
                dist_we    = src_ok;
                dist_waddr = src_i;
                dist_wdata = '0;
            end
            ST_EDGE_CHK: dist_raddr = other;
            ST_RELAX:    dist_we    = ~r_reached[r_o] | (nd < q_dist);
            default:     dist_raddr = r_idx[NIW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (edge_we) begin
            r_edge_mem[r_count[EIW-1:0]] <= {i_req.node_a[NIW-1:0], i_req.node_b[NIW-1:0],
                                            i_req.weight};
        end
        r_edge_q <= r_edge_mem[r_e[EIW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (dist_we) begin
            r_dist_mem[dist_waddr] <= dist_wdata;
        end
        r_dist_q <= r_dist_mem[dist_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_reached <= '0;
            r_settled <= '0;
            r_p_vld   <= 1'b0;
            r_found   <= 1'b0;
            r_done    <= 1'b0;
            r_o_valid <= 1'b0;
            r_e       <= '0;
            r_idx     <= '0;
        end else begin
            r_done    <= (r_state == ST_OUT) & ~scan_more;
            r_o_valid <= r_p_vld & (r_state == ST_OUT);
            if (r_p_vld && r_state == ST_SEL && cand) begin
                r_found <= 1'b1;
                r_u     <= r_p_idx;
                r_du    <= q_dist;
            end
            if (r_p_vld && r_state == ST_OUT) begin
                r_o_node     <= NODE_W'(r_p_idx);
                r_o_reached  <= r_reached[r_p_idx];
                r_o_distance <= r_reached[r_p_idx] ? q_dist : '0;
                r_o_has_pred <= r_reached[r_p_idx] & (NODE_W'(r_p_idx) != i_src);
                r_o_pred     <= (r_reached[r_p_idx] & (NODE_W'(r_p_idx) != i_src)) ?
                                NODE_W'(q_prev) : '0;
                r_o_dropped  <= r_dropped;
                r_o_last     <= (NCW'(r_p_idx) + NCW'(1)) == i_n;
            end
            unique case (r_state)
                ST_LOAD: begin
                    if (o_req_pop) begin
                        if (edge_we) begin
                            r_count <= r_count + ECW'(1);
                        end else begin
                            r_dropped <= 1'b1;
                        end
                        if (i_req.last_edge) begin
                            r_state <= ST_INIT;
                        end
                    end
                end
                ST_INIT: begin
                    r_reached <= src_ok ? (MAX_NODES'(1) << src_i) : '0;
                    r_settled <= '0;
                    r_idx     <= '0;
                    r_p_vld   <= 1'b0;
                    r_found   <= 1'b0;
                    r_state   <= src_ok ? ST_SEL : ST_OUT;
                end
                ST_SEL, ST_OUT: begin
                    // scan nodes in index order; compare or emit in the cycle after the read
                    if (scan_more) begin
                        r_idx   <= r_idx + NCW'(1);
                        r_p_vld <= 1'b1;
                        r_p_idx <= r_idx[NIW-1:0];
                    end else begin
                        r_p_vld <= 1'b0;
                        if (r_state == ST_SEL) begin
                            r_state <= ST_PICK;
                        end else begin
                            r_count   <= '0;
                            r_dropped <= 1'b0;
                            r_state   <= ST_LOAD;
                        end
                    end
                end
                ST_PICK: begin
                    r_idx <= '0;
                    if (r_found) begin
                        r_settled[r_u] <= 1'b1;
                        r_e            <= '0;
                        r_state        <= ST_EDGE_RD;
                    end else begin
                        r_state <= ST_OUT;
                    end
                end
                ST_EDGE_RD: begin
                    if (r_e == r_count) begin
                        r_idx   <= '0;
                        r_p_vld <= 1'b0;
                        r_found <= 1'b0;
                        r_state <= ST_SEL;
                    end else begin
                        r_state <= ST_EDGE_CHK;
                    end
                end
                ST_EDGE_CHK: begin
                    // relax only edges touching the settled node once; drop self loops
                    if (ed_ok && (hit_a ^ hit_b)) begin
                        r_o     <= other;
                        r_w     <= ed_w;
                        r_state <= ST_RELAX;
                    end else begin
                        r_e     <= r_e + ECW'(1);
                        r_state <= ST_EDGE_RD;
                    end
                end
                ST_RELAX: begin
                    if (dist_we) begin
                        r_reached[r_o] <= 1'b1;
                    end
                    r_e     <= r_e + ECW'(1);
                    r_state <= ST_EDGE_RD;
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    assign o_stat.done       = r_done;
    assign o_valid           = r_o_valid;
    assign o_node            = r_o_node;
    assign o_reached         = r_o_reached;
    assign o_distance        = r_o_distance;
    assign o_has_predecessor = r_o_has_pred;
    assign o_predecessor     = r_o_pred;
    assign o_edge_dropped    = r_o_dropped;
    assign o_last_node       = r_o_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ECW'(MAX_EDGES))
        else $error("edge count beyond capacity");

    a_strobe_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> ($past(r_state) == ST_OUT))
        else $error("result strobe outside output scan");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_last) |-> (r_state == ST_LOAD && r_count == '0 && !r_dropped))
        else $error("graph not cleared after final result");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_LOAD) |-> !o_req_pop)
        else $error("request taken during search");

endmodule

[src/shortest_path_search.sv]
// Top level of the shortest-path search block: configuration registers and
// the front and back parts. Depends on sps_pkg, sps_front and sps_back.
//
// Edges are requested one per cycle (start high while busy is low) and are
// stored; an edge naming a node at or above the node count, or one beyond
// the MAX_EDGES capacity, is dropped and reported on every result of that
// graph. The request flagged last_edge is itself an edge and starts the search
// from source_node. Results then come out one per cycle on o_valid, for nodes
// 0 to node_count-1 in order; the receiver cannot stall them, so take each
// one in the cycle it is shown. busy stays high from the last edge until the
// final result has left. The search settles one node per round: each round
// scans all nodes through the single distance memory port in ST_SEL, settles
// the nearest reached node in ST_PICK, then walks every stored edge through
// ST_EDGE_RD and ST_EDGE_CHK, with a ST_RELAX step for each edge that touches
// the settled node, and closes in ST_EDGE_RD. The search opens with a setup
// step in ST_INIT; after the last round a final scan finds nothing left and
// the output scan in ST_OUT follows. Write configuration only while busy is
// low and no results are pending.
module shortest_path_search
    import sps_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int MAX_EDGES = DEF_MAX_EDGES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [CNT_W-1:0]    i_cfg_data,
    input  logic [NODE_W-1:0]   i_node_a,
    input  logic [NODE_W-1:0]   i_node_b,
    input  logic [WEIGHT_W-1:0] i_weight,
    input  logic                i_last_edge,
    output logic                o_valid,
    output logic [NODE_W-1:0]   o_node,
    output logic                o_reached,
    output logic [DIST_W-1:0]   o_distance,
    output logic                o_has_predecessor,
    output logic [NODE_W-1:0]   o_predecessor,
    output logic                o_edge_dropped,
    output logic                o_last_node
);

    localparam int NCW = $clog2(MAX_NODES + 1);

    logic [NODE_W-1:0] r_source;
    logic [CNT_W-1:0]  r_node_count;
    logic [NCW-1:0]    eff_n;
    t_edge_req         req;
    logic              req_valid;
    logic              req_pop;
    t_back_stat        stat;

    // configuration registers; the user must write them only while idle, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source     <= '0;
            r_node_count <= CNT_W'(DEF_MAX_NODES);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SOURCE: r_source     <= i_cfg_data[NODE_W-1:0];
                REG_COUNT:  r_node_count <= i_cfg_data;
                default:    r_source     <= r_source;
            endcase
        end
    end

    // clamp the node count to 1 .. MAX_NODES
    always_comb begin
        priority if (r_node_count == '0) begin
            eff_n = NCW'(1);
        end else if (r_node_count > CNT_W'(MAX_NODES)) begin
            eff_n = NCW'(MAX_NODES);
        end else begin
            eff_n = NCW'(r_node_count);
        end
    end

    sps_front #(
        .MAX_NODES (MAX_NODES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_node_a    (i_node_a),
        .i_node_b    (i_node_b),
        .i_weight    (i_weight),
        .i_last_edge (i_last_edge),
        .i_n         (eff_n),
        .o_req       (req),
        .o_req_valid (req_valid),
        .i_req_pop   (req_pop),
        .i_stat      (stat)
    );

    sps_back #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_req             (req),
        .i_req_valid       (req_valid),
        .o_req_pop         (req_pop),
        .i_n               (eff_n),
        .i_src             (r_source),
        .o_stat            (stat),
        .o_valid           (o_valid),
        .o_node            (o_node),
        .o_reached         (o_reached),
        .o_distance        (o_distance),
        .o_has_predecessor (o_has_predecessor),
        .o_predecessor     (o_predecessor),
        .o_edge_dropped    (o_edge_dropped),
        .o_last_node       (o_last_node)
    );

endmodule

[tb/testbench.sv]
// Self-checking testbench for shortest_path_search: edge requests in, per-node results out.
// Depends on sps_pkg and the RTL; holds its own shortest-path predictor.
module testbench;
    import sps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // one expected or observed per-node result
    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic              reached;
        logic [DIST_W-1:0] distance;
        logic              has_pred;
        logic [NODE_W-1:0] pred;
        logic              dropped;
        logic              last_node;
    } t_route;

    localparam int          NODES    = DEF_MAX_NODES;
    localparam int          EDGES    = DEF_MAX_EDGES;
    localparam logic [23:0] DIST_TOP = 24'hFFFFFF;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic                i_cfg_we = 1'b0;
    logic                i_cfg_idx = REG_SOURCE;
    logic [CNT_W-1:0]    i_cfg_data = '0;
    logic [NODE_W-1:0]   i_node_a = '0;
    logic [NODE_W-1:0]   i_node_b = '0;
    logic [WEIGHT_W-1:0] i_weight = '0;
    logic                i_last_edge = 1'b0;
    logic                o_valid;
    logic [NODE_W-1:0]   o_node;
    logic                o_reached;
    logic [DIST_W-1:0]   o_distance;
    logic                o_has_predecessor;
    logic [NODE_W-1:0]   o_predecessor;
    logic                o_edge_dropped;
    logic                o_last_node;

    shortest_path_search DUT (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state: graph under construction and the configuration
    logic [NODE_W-1:0]   graph_a [EDGES];
    logic [NODE_W-1:0]   graph_b [EDGES];
    logic [WEIGHT_W-1:0] graph_w [EDGES];
    int                  graph_edges = 0;
    logic                graph_dropped = 1'b0;
    logic [NODE_W-1:0]   src_node = '0;
    logic [CNT_W-1:0]    node_cnt = 7'd64;

    t_route route_q[$];
    int     fail_cnt = 0;
    int     idle_pct = 0;

    // store one accepted edge; on the last one, search and queue every node's route
    task automatic take_edge(input logic [5:0] a, input logic [5:0] b,
                             input logic [15:0] w, input logic last);
        int          n;
        int          u;
        bit          found;
        logic [24:0] nd;
        logic [23:0] best [NODES];
        logic [5:0]  prev [NODES];
        bit          seen [NODES];
        bit          done [NODES];
        t_route      r;
        n = (node_cnt == 0) ? 1 : (node_cnt > NODES ? NODES : int'(node_cnt));
        if (graph_edges >= EDGES || a >= n || b >= n) begin
            graph_dropped = 1'b1;
        end else begin
            graph_a[graph_edges] = a;
            graph_b[graph_edges] = b;
            graph_w[graph_edges] = w;
            graph_edges++;
        end
        if (!last) return;
        for (int i = 0; i < NODES; i++) begin
            best[i] = '0; prev[i] = '0; seen[i] = 0; done[i] = 0;
        end
        if (src_node < n) begin
            seen[src_node] = 1;
            for (int step = 0; step < n; step++) begin
                found = 0;
                u = 0;
                // lowest distance wins, lowest index on a tie
                for (int i = 0; i < n; i++)
                    if (seen[i] && !done[i] && (!found || best[i] < best[u])) begin
                        u = i;
                        found = 1;
                    end
                if (!found) break;
                done[u] = 1;
                for (int e = 0; e < graph_edges; e++) begin
                    if (graph_a[e] >= n || graph_b[e] >= n) continue;
                    nd = best[u] + graph_w[e];
                    if (nd > DIST_TOP) nd = DIST_TOP;
                    // relax only on a strictly shorter path
                    if (graph_a[e] == u &&
                        (!seen[graph_b[e]] || nd[23:0] < best[graph_b[e]])) begin
                        seen[graph_b[e]] = 1; best[graph_b[e]] = nd[23:0];
                        prev[graph_b[e]] = u[5:0];
                    end
                    if (graph_b[e] == u &&
                        (!seen[graph_a[e]] || nd[23:0] < best[graph_a[e]])) begin
                        seen[graph_a[e]] = 1; best[graph_a[e]] = nd[23:0];
                        prev[graph_a[e]] = u[5:0];
                    end
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            r.node      = i[5:0];
            r.reached   = seen[i];
            r.distance  = seen[i] ? best[i] : '0;
            r.has_pred  = seen[i] && i != src_node;
            r.pred      = r.has_pred ? prev[i] : '0;
            r.dropped   = graph_dropped;
            r.last_node = (i == n - 1);
            route_q     = {route_q, r};
        end
        // next request starts a fresh graph
        graph_edges   = 0;
        graph_dropped = 1'b0;
    endtask

    // hold the request until the block takes it; idle beforehand at random
    task automatic send_edge(input logic [5:0] a, input logic [5:0] b,
                             input logic [15:0] w, input logic last);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_node_a    <= a;
        i_node_b    <= b;
        i_weight    <= w;
        i_last_edge <= last;
        do @(posedge i_clk); while (busy);
        take_edge(a, b, w, last);
    endtask

    // drop start and wait for every route to leave and busy to fall
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (route_q.size() != 0 || busy);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [6:0] val);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_SOURCE) src_node = val[5:0];
        else node_cnt = val;
    endtask

    // ties, self loop, zero and full weights, bad index, strict relaxation
    task automatic test_small_graph();
        write_reg(REG_COUNT, 7'd8);
        write_reg(REG_SOURCE, 7'd0);
        send_edge(6'd0, 6'd1, 16'd5, 1'b0);
        send_edge(6'd0, 6'd2, 16'd5, 1'b0);
        send_edge(6'd1, 6'd3, 16'd3, 1'b0);
        send_edge(6'd2, 6'd3, 16'd3, 1'b0);   // equal path: keep first predecessor
        send_edge(6'd3, 6'd3, 16'd0, 1'b0);   // self loop
        send_edge(6'd4, 6'd0, 16'd0, 1'b0);
        send_edge(6'd4, 6'd5, 16'hFFFF, 1'b0);
        send_edge(6'd9, 6'd1, 16'd1, 1'b0);   // bad index, dropped
        send_edge(6'd6, 6'd7, 16'd1, 1'b1);   // island left unreached
        // new graph, source moved and no drops
        write_reg(REG_SOURCE, 7'd7);
        send_edge(6'd7, 6'd6, 16'd2, 1'b0);
        send_edge(6'd6, 6'd0, 16'd1, 1'b1);
    endtask

    // full node range: a chain through all 64 nodes at maximum weight
    task automatic test_long_chain();
        write_reg(REG_COUNT, 7'd64);
        write_reg(REG_SOURCE, 7'd63);
        for (int i = 0; i < 63; i++)
            send_edge(i[5:0], 6'(i + 1), 16'hFFFF, i == 62);
    endtask

    // source outside the graph, and node counts clamped from both sides
    task automatic test_count_limits();
        write_reg(REG_COUNT, 7'd4);
        write_reg(REG_SOURCE, 7'd10);
        send_edge(6'd0, 6'd1, 16'd1, 1'b1);
        write_reg(REG_COUNT, 7'd0);
        write_reg(REG_SOURCE, 7'd0);
        send_edge(6'd0, 6'd0, 16'd7, 1'b0);
        send_edge(6'd1, 6'd0, 16'd7, 1'b1);
        write_reg(REG_COUNT, 7'd127);
        send_edge(6'd0, 6'd63, 16'd9, 1'b0);
        send_edge(6'd63, 6'd62, 16'd1, 1'b1);
    endtask

    // random graphs, mostly small, with occasional bad edges and config changes
    task automatic test_random_graphs(input int graphs);
        int          n;
        int          len;
        logic [5:0]  a;
        logic [5:0]  b;
        for (int g = 0; g < graphs; g++) begin
            if ($urandom_range(2) == 0) begin
                n = ($urandom_range(7) == 0) ? 64 : $urandom_range(2, 12);
                write_reg(REG_COUNT, 7'(n));
                write_reg(REG_SOURCE, ($urandom_range(9) == 0) ?
                          7'(6'($urandom)) : 7'($urandom_range(n - 1)));
            end
            n   = (node_cnt == 0) ? 1 : (node_cnt > NODES ? NODES : int'(node_cnt));
            len = $urandom_range(1, 9);
            for (int e = 0; e < len; e++) begin
                if ($urandom_range(9) == 0) begin
                    a = 6'($urandom);
                    b = 6'($urandom);
                end else begin
                    a = 6'($urandom_range(n - 1));
                    b = 6'($urandom_range(n - 1));
                end
                send_edge(a, b, ($urandom_range(3) == 0) ? 16'($urandom_range(7))
                                                         : 16'($urandom), e == len - 1);
            end
        end
    endtask

    // compare each shown route with the oldest prediction
    always @(posedge i_clk) begin
        t_route got;
        t_route want;
        if (i_rst_n && o_valid) begin
            got = '{o_node, o_reached, o_distance, o_has_predecessor,
                    o_predecessor, o_edge_dropped, o_last_node};
            if (route_q.size() == 0) begin
                $display("%0t: unexpected route node=%0d", $realtime, o_node);
                fail_cnt++;
            end else begin
                want = route_q.pop_front();
                if (got !== want) begin
                    $display("%0t: expected node=%0d r=%0d d=%0d hp=%0d p=%0d drop=%0d last=%0d",
                             $realtime, want.node, want.reached, want.distance,
                             want.has_pred, want.pred, want.dropped, want.last_node);
                    $display("%0t: actual   node=%0d r=%0d d=%0d hp=%0d p=%0d drop=%0d last=%0d",
                             $realtime, got.node, got.reached, got.distance,
                             got.has_pred, got.pred, got.dropped, got.last_node);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_small_graph();
        test_long_chain();
        test_count_limits();
        idle_pct = 8;
        test_random_graphs(3);
        idle_pct = 50;
        test_random_graphs(3);
        idle_pct = 0;
        test_random_graphs(3);
        drain();
        repeat (20) @(posedge i_clk);
        if (fail_cnt == 0 && route_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
